FILE: hdl/pidfd_pkg.sv
// Package for the filtered-derivative PID block: beat structs, register
// indexes, sequencer states and fixed widths. No dependencies.
package pidfd_pkg;

	localparam int unsigned ValueWidth = 32;
	localparam int unsigned GainWidth  = 31;
	localparam int unsigned CfgWidth   = 32;
	localparam int unsigned IdxWidth   = 3;

	typedef enum logic [IdxWidth-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_FILTER_TC   = 3'd3,
		REG_SAMPLE_PER  = 3'd4,
		REG_OUT_MIN     = 3'd5,
		REG_OUT_MAX     = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] target_value;
		logic signed [31:0] measured_value;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] drive_value;
		logic               saturated;
	} out_beat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROP,
		ST_KI,
		ST_INTEG,
		ST_DG,
		ST_DF,
		ST_DIV,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;

endpackage

FILE: hdl/pidfd_mul.sv
// Shared signed multiplier that accumulates 32x32 partial products in turn.
// Depends on pidfd_pkg.
module pidfd_mul #(
	parameter int unsigned AW = 49,
	parameter int unsigned BW = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [AW-1:0]        a,
	input  logic        [BW-1:0]        b,
	output logic                        done,
	output logic signed [AW+BW-1:0]     p
);
	import pidfd_pkg::*;

	localparam int unsigned PW = AW + BW;

	logic        [63:0]   amag_q;
	logic        [63:0]   b_q;
	logic                 neg_q;
	logic        [2:0]    step_q;
	logic        [127:0]  acc_q;
	logic        [63:0]   pp;
	logic        [31:0]   pa;
	logic        [31:0]   pb;
	logic        [6:0]    sh;
	logic        [AW-1:0] amag;

	assign amag = a[AW-1] ? AW'(-a) : AW'(a);

	always_comb begin
		case (step_q[1:0])
			2'd0: begin pa = amag_q[31:0];  pb = b_q[31:0];  sh = 7'd0;  end
			2'd1: begin pa = amag_q[63:32]; pb = b_q[31:0];  sh = 7'd32; end
			2'd2: begin pa = amag_q[31:0];  pb = b_q[63:32]; sh = 7'd32; end
			default: begin pa = amag_q[63:32]; pb = b_q[63:32]; sh = 7'd64; end
		endcase
		pp = {32'd0, pa} * {32'd0, pb};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 3'd0;
			done   <= 1'b0;
		end else begin
			done <= !start && (step_q == 3'd7);
			if (start) begin
				step_q <= 3'd4;
			end else if (step_q != 3'd0) begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			amag_q <= 64'(amag);
			b_q    <= 64'(b);
			neg_q  <= a[AW-1];
			acc_q  <= '0;
		end else if (step_q != 3'd0) begin
			acc_q <= acc_q + ({64'd0, pp} << sh);
		end
	end

	assign p = neg_q ? -$signed(PW'(acc_q)) : $signed(PW'(acc_q));

endmodule

FILE: hdl/pidfd_div.sv
// Restoring divider, one quotient bit per cycle, for the derivative filter.
// Depends on pidfd_pkg.
module pidfd_div #(
	parameter int unsigned NW = 128,
	parameter int unsigned DW = 33
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NW-1:0]   num,
	input  logic [DW-1:0]   den,
	output logic            done,
	output logic [NW-1:0]   quo
);
	import pidfd_pkg::*;

	localparam int unsigned CW = $clog2(NW + 1);

	div_ctl_t          ctl_q;
	logic [CW-1:0]     cnt_q;
	logic [DW-1:0]     den_q;
	logic [DW:0]       rem_q;
	logic [NW-1:0]     n_q;
	logic [DW:0]       trial;

	assign trial = {rem_q[DW-1:0], n_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done        <= !start && ctl_q.busy && (cnt_q == CW'(1));
			ctl_q.start <= start;
			if (start) begin
				ctl_q.busy <= 1'b1;
				cnt_q      <= CW'(NW);
			end else if (ctl_q.busy) begin
				cnt_q      <= cnt_q - CW'(1);
				ctl_q.busy <= (cnt_q != CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			den_q <= den;
			rem_q <= '0;
			quo   <= '0;
		end else if (ctl_q.busy) begin
			n_q <= n_q << 1;
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo   <= {quo[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo   <= {quo[NW-2:0], 1'b0};
			end
		end
	end

endmodule

FILE: hdl/pid_with_filtered_derivative.sv
// Top level of the PID controller with trapezoidal integrator, dynamic
// anti-windup clamp and bilinear low-pass derivative on the measurement.
// Depends on pidfd_pkg, pidfd_mul and pidfd_div.
//
// Usage: configuration is written through cfg_we/cfg_idx/cfg_data while idle.
// Each input beat (in_valid/in_stall) carries a set point and a measurement
// and produces exactly one output beat (out_valid/out_stall) with the clamped
// drive value and a saturation flag. One multiplier built from 32x32 partial
// products serves all five products in turn, and a restoring divider gives one
// quotient bit per cycle over 128 bits. The next input beat can be accepted in
// the cycle the result beat is presented, so one item must finish before the
// next one starts. A result that waits in the output register does not block
// the input; only the final step of the next item waits until the output
// register is free, and a stalled result simply holds.
// Reset clears the integrator, the derivative filter and the stored error and
// measurement, and loads the register reset values.
module pid_with_filtered_derivative #(
	parameter int unsigned FRAC_BITS   = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  pidfd_pkg::in_beat_t             in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output pidfd_pkg::out_beat_t            out_data,
	input  logic                            cfg_we,
	input  logic [pidfd_pkg::IdxWidth-1:0]  cfg_idx,
	input  logic [pidfd_pkg::CfgWidth-1:0]  cfg_data
);
	import pidfd_pkg::*;

	localparam int unsigned VW = ValueWidth;
	localparam int unsigned AW = VW + 2;
	localparam int unsigned BW = 64;
	localparam int unsigned PW = AW + BW;
	localparam int unsigned NW = 128;
	localparam int unsigned DW = 33;
	localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

	function automatic logic signed [VW-1:0] sat_p(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] hi;
		logic signed [PW-1:0] lo;
		hi = PW'(VMAX);
		lo = PW'(VMIN);
		if (v > hi) return VMAX;
		if (v < lo) return VMIN;
		return VW'(v);
	endfunction

	function automatic logic signed [VW-1:0] sat_w(input logic signed [VW+1:0] v);
		if (v > (VW+2)'(VMAX)) return VMAX;
		if (v < (VW+2)'(VMIN)) return VMIN;
		return VW'(v);
	endfunction

	function automatic logic signed [VW-1:0] sat_32(input logic signed [31:0] v);
		return sat_w((VW+2)'(v));
	endfunction

	logic [GainWidth-1:0] kp_q, ki_q, kd_q, tf_q, ts_q;
	logic signed [31:0]   omin_q, omax_q;

	logic signed [VW-1:0] integ_acc_q, last_err_q, deriv_q, last_meas_q;
	logic signed [VW-1:0] meas_q, err_q, prop_q, integ_q, omin_v, omax_v;
	logic signed [PW-1:0] dnum_q;
	logic                 dneg_q;
	out_beat_t            res_q;
	logic                 res_valid_q;
	logic                 res_free;

	state_t state_q, state_d;

	logic                  mul_start, mul_done;
	logic signed [AW-1:0]  mul_a;
	logic signed [AW-1:0]  mul_a_q;
	logic        [BW-1:0]  mul_b;
	logic signed [PW-1:0]  mul_p;
	logic                  div_start, div_done;
	logic        [NW-1:0]  div_num, div_quo;
	logic        [DW-1:0]  den;
	logic signed [VW+1:0]  tgt_w, meas_w, total_w;
	logic signed [VW-1:0]  lmin, lmax, integ_c, dq_sat;
	logic signed [PW-1:0]  ishift, isum, dq_s;
	logic signed [DW:0]    dcoef;
	logic signed [PW-1:0]  df_fix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= '0;
			ki_q   <= '0;
			kd_q   <= '0;
			tf_q   <= '0;
			ts_q   <= GainWidth'(65536);
			omin_q <= 32'sh8000_0000;
			omax_q <= 32'sh7fff_ffff;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_PROP_GAIN:  kp_q   <= cfg_data[GainWidth-1:0];
				REG_INTEG_GAIN: ki_q   <= cfg_data[GainWidth-1:0];
				REG_DERIV_GAIN: kd_q   <= cfg_data[GainWidth-1:0];
				REG_FILTER_TC:  tf_q   <= cfg_data[GainWidth-1:0];
				REG_SAMPLE_PER: ts_q   <= cfg_data[GainWidth-1:0];
				REG_OUT_MIN:    omin_q <= cfg_data;
				REG_OUT_MAX:    omax_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign omin_v  = sat_32(omin_q);
	assign omax_v  = sat_32(omax_q);
	assign tgt_w   = (VW+2)'(sat_32(in_data.target_value));
	assign meas_w  = (VW+2)'(sat_32(in_data.measured_value));
	assign den     = {1'b0, tf_q, 1'b0} + DW'(ts_q);
	assign dcoef   = $signed({2'b0, tf_q, 1'b0}) - $signed((DW+1)'(ts_q));
	assign ishift  = mul_p >>> (2 * FRAC_BITS + 1);
	assign isum    = PW'(integ_acc_q) + ishift;
	assign lmax    = (omax_v > prop_q) ? sat_w((VW+2)'(omax_v) - (VW+2)'(prop_q)) : '0;
	assign lmin    = (omin_v < prop_q) ? sat_w((VW+2)'(omin_v) - (VW+2)'(prop_q)) : '0;
	assign div_num = dneg_q ? NW'(-dnum_q) : NW'(dnum_q);
	assign dq_s    = dneg_q ? -$signed(PW'(div_quo)) : $signed(PW'(div_quo));
	assign dq_sat  = (den == '0) ? '0 : sat_p(dq_s);
	assign total_w = (VW+2)'(prop_q) + (VW+2)'(integ_q) + (VW+2)'(dq_sat);
	assign res_free = !res_valid_q || !out_stall;

	always_comb begin
		integ_c = sat_p(isum);
		if (integ_c < lmin) integ_c = lmin;
		if (integ_c > lmax) integ_c = lmax;
	end

	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d   = ST_PROP;
					mul_start = 1'b1;
					mul_a     = AW'(sat_w(tgt_w - meas_w));
					mul_b     = BW'(kp_q);
				end
			end
			ST_PROP: begin
				if (mul_done) begin
					state_d   = ST_KI;
					mul_start = 1'b1;
					mul_a     = AW'(ki_q);
					mul_b     = BW'(ts_q);
				end
			end
			ST_KI: begin
				if (mul_done) begin
					state_d   = ST_INTEG;
					mul_start = 1'b1;
					mul_a     = AW'(err_q) + AW'(last_err_q);
					mul_b     = BW'(mul_p);
				end
			end
			ST_INTEG: begin
				if (mul_done) begin
					state_d   = ST_DG;
					mul_start = 1'b1;
					mul_a     = AW'(meas_q) - AW'(last_meas_q);
					mul_b     = BW'({kd_q, 1'b0});
				end
			end
			ST_DG: begin
				if (mul_done) begin
					state_d   = ST_DF;
					mul_start = 1'b1;
					mul_a     = AW'(dcoef);
					mul_b     = BW'($signed(deriv_q));
				end
			end
			ST_DF: begin
				if (mul_done) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				div_start = 1'b1;
				state_d   = ST_SUM;
			end
			ST_SUM: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// The signed derivative product needs the full signed B operand, so the
	// filter product sign-corrects the unsigned partial-product result below.
	assign df_fix = deriv_q[VW-1] ? mul_p - (PW'(mul_a_q) <<< BW) : mul_p;

	always_ff @(posedge clk) begin
		if (mul_start) mul_a_q <= mul_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			integ_acc_q <= '0;
			last_err_q  <= '0;
			deriv_q     <= '0;
			last_meas_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && res_free) begin
				res_valid_q <= 1'b1;
				integ_acc_q <= integ_q;
				deriv_q     <= dq_sat;
				last_err_q  <= err_q;
				last_meas_q <= meas_q;
			end else if (res_valid_q && !out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (state_d == ST_PROP) begin
					meas_q <= VW'(meas_w);
					err_q  <= sat_w(tgt_w - meas_w);
				end
			end
			ST_PROP: if (mul_done) prop_q <= sat_p(mul_p >>> FRAC_BITS);
			ST_INTEG: if (mul_done) integ_q <= integ_c;
			ST_DG: if (mul_done) dnum_q <= -mul_p;
			ST_DF: begin
				if (mul_done) begin
					dnum_q <= dnum_q + df_fix;
					dneg_q <= (dnum_q + df_fix) < 0;
				end
			end
			ST_OUT: begin
				if (res_free) begin
					if (total_w < (VW+2)'(omin_v)) begin
						res_q.drive_value <= 32'(omin_v);
						res_q.saturated   <= 1'b1;
					end else if (total_w > (VW+2)'(omax_v)) begin
						res_q.drive_value <= 32'(omax_v);
						res_q.saturated   <= 1'b1;
					end else begin
						res_q.drive_value <= 32'(total_w);
						res_q.saturated   <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	pidfd_mul #(.AW(AW), .BW(BW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .p(mul_p)
	);

	pidfd_div #(.NW(NW), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(den),
		.done(div_done), .quo(div_quo)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	a_one_job: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_PROP))
		else $error("accepted beat did not start the sequencer");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input accepted while busy");
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");

endmodule

FILE: verif/pid_with_filtered_derivative_tb.sv
// Self-checking testbench for pid_with_filtered_derivative: a queue-fed driver,
// a bit-exact controller predictor and a monitor that checks every output beat.
// Depends on pidfd_pkg and the RTL of the block.
module pid_with_filtered_derivative_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pidfd_pkg::*;

	localparam logic [IdxWidth-1:0] RegUnused = 3'd7;
	localparam int unsigned CycleLimit = 2000000;
	localparam int unsigned SettleCycles = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_beat_t out_data;
	logic cfg_we = 1'b0;
	logic [IdxWidth-1:0] cfg_idx = '0;
	logic [CfgWidth-1:0] cfg_data = '0;

	pid_with_filtered_derivative uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Controller settings and state as the predictor sees them.
	logic [GainWidth-1:0] kp, ki, kd, filt_tc, samp_per;
	logic signed [31:0] lim_lo, lim_hi;
	logic signed [31:0] integ_acc, prev_err, deriv_st, prev_meas;

	in_beat_t pending_q[$];
	out_beat_t expected_drive_q[$];
	int unsigned errors = 0;
	int unsigned beats_in = 0;
	int unsigned beats_out = 0;
	int unsigned sat_seen = 0;
	int unsigned cycles = 0;
	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	bit took = 1'b0;

	function automatic logic signed [31:0] clip32(input logic signed [127:0] v);
		if (v > 128'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -128'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	task automatic compute_drive(input in_beat_t b);
		logic signed [127:0] t, m, e, p, ig, lo, hi, num, den, q, tot, g, s, f;
		out_beat_t r;
		t = b.target_value;
		m = b.measured_value;
		e = clip32(t - m);
		g = kp;
		p = clip32((e * g) >>> 16);
		g = ki;
		s = samp_per;
		g = g * s;
		ig = clip32(integ_acc + (((e + prev_err) * g) >>> 33));
		lo = 0;
		hi = 0;
		if (lim_hi > p) begin
			hi = clip32(lim_hi - p);
		end
		if (lim_lo < p) begin
			lo = clip32(lim_lo - p);
		end
		if (ig < lo) begin
			ig = lo;
		end
		if (ig > hi) begin
			ig = hi;
		end
		g = kd;
		f = filt_tc;
		num = -((m - prev_meas) * (2 * g)) + ((2 * f - s) * deriv_st);
		den = 2 * f + s;
		if (den == 0) begin
			q = 0;
		end else begin
			q = clip32(num / den);
		end
		tot = p + ig + q;
		r.saturated = 1'b0;
		if (tot < lim_lo) begin
			tot = lim_lo;
			r.saturated = 1'b1;
		end else if (tot > lim_hi) begin
			tot = lim_hi;
			r.saturated = 1'b1;
		end
		r.drive_value = tot[31:0];
		integ_acc = ig[31:0];
		deriv_st = q[31:0];
		prev_err = e[31:0];
		prev_meas = m[31:0];
		expected_drive_q.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("MISMATCH beat %0d %s: got %h expected %h", beats_out, what, got, want);
	endtask

	task automatic write_reg(input logic [IdxWidth-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			REG_PROP_GAIN: kp = val[30:0];
			REG_INTEG_GAIN: ki = val[30:0];
			REG_DERIV_GAIN: kd = val[30:0];
			REG_FILTER_TC: filt_tc = val[30:0];
			REG_SAMPLE_PER: samp_per = val[30:0];
			REG_OUT_MIN: lim_lo = val;
			REG_OUT_MAX: lim_hi = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_all(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d,
			input logic [31:0] tc, input logic [31:0] sp, input logic [31:0] lo,
			input logic [31:0] hi);
		write_reg(REG_PROP_GAIN, p);
		write_reg(REG_INTEG_GAIN, i);
		write_reg(REG_DERIV_GAIN, d);
		write_reg(REG_FILTER_TC, tc);
		write_reg(REG_SAMPLE_PER, sp);
		write_reg(REG_OUT_MIN, lo);
		write_reg(REG_OUT_MAX, hi);
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || in_valid || expected_drive_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SettleCycles) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value(input logic [31:0] near);
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
			2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return near + $urandom_range(0, 32'h0003ffff) - 32'h00020000;
		endcase
	endfunction

	task automatic push_random(input int unsigned n);
		in_beat_t b;
		logic [31:0] sp_val;
		sp_val = $urandom_range(0, 32'h0007ffff) - 32'h00040000;
		for (int unsigned k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				sp_val = pick_value(sp_val);
			end
			b.target_value = sp_val;
			b.measured_value = pick_value(sp_val);
			pending_q.push_back(b);
		end
	endtask

	task automatic push_item(input logic [31:0] t, input logic [31:0] m);
		in_beat_t b;
		b.target_value = t;
		b.measured_value = m;
		pending_q.push_back(b);
	endtask

	// Input side: the predictor runs on every accepted beat.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
		if (in_valid && !in_stall) begin
			compute_drive(in_data);
			beats_in++;
			took = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (!in_valid || took) begin
			took = 1'b0;
			if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
				in_data <= pending_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_idle);
	end

	always @(posedge clk) begin
		out_beat_t want;
		if (out_valid && !out_stall) begin
			if (expected_drive_q.size() == 0) begin
				report_mismatch("unexpected beat", out_data.drive_value, 32'h0);
			end else begin
				want = expected_drive_q.pop_front();
				if (out_data.drive_value !== want.drive_value) begin
					report_mismatch("drive_value", out_data.drive_value, want.drive_value);
				end
				if (out_data.saturated !== want.saturated) begin
					report_mismatch("saturated", 32'(out_data.saturated),
						32'(want.saturated));
				end
				sat_seen += want.saturated;
			end
			beats_out++;
		end
	end

	initial begin
		kp = '0;
		ki = '0;
		kd = '0;
		filt_tc = '0;
		samp_per = 31'd65536;
		lim_lo = 32'sh80000000;
		lim_hi = 32'sh7fffffff;
		integ_acc = '0;
		prev_err = '0;
		deriv_st = '0;
		prev_meas = '0;
		send_idle = 24;
		recv_idle = 51;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings first, then moderate gains, then corners.
		push_item(32'h00010000, 32'h0);
		push_item(32'h7fffffff, 32'h80000000);
		push_item(32'h80000000, 32'h7fffffff);
		drain();
		set_all(32'h00010000, 32'h00008000, 32'h00004000, 32'h00001999, 32'h0000028f,
			32'hff9c0000, 32'h00640000);
		write_reg(RegUnused, 32'hffffffff);
		push_item(32'h0, 32'h0);
		push_item(32'h7fffffff, 32'h7fffffff);
		push_item(32'h80000000, 32'h80000000);
		push_item(32'h7fffffff, 32'h0);
		push_item(32'h80000000, 32'h0);
		push_item(32'h0, 32'h7fffffff);
		push_item(32'h0, 32'h80000000);
		push_item(32'h00050000, 32'h00040000);
		push_item(32'h00050000, 32'h00048000);
		push_item(32'hfffb0000, 32'h00000000);
		push_item(32'h00000001, 32'hffffffff);
		push_item(32'haaaaaaaa, 32'h55555555);
		push_item(32'h55555555, 32'haaaaaaaa);
		drain();
		set_all(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h0, 32'hffffffff,
			32'h80000000, 32'h7fffffff);
		push_item(32'h7fffffff, 32'h80000000);
		push_item(32'h80000000, 32'h7fffffff);
		push_item(32'h00000001, 32'h0);
		drain();
		// Crossed limits.
		set_all(32'h00020000, 32'h00010000, 32'h00010000, 32'h7fffffff, 32'h00000001,
			32'h00100000, 32'hfff00000);
		push_item(32'h0, 32'h0);
		push_item(32'h00200000, 32'h0);
		push_item(32'hffe00000, 32'h0);
		drain();

		set_all(32'h00018000, 32'h00004000, 32'h00002000, 32'h00000ccc, 32'h00000148,
			32'hfe000000, 32'h02000000);
		push_random(150);
		drain();
		set_all($urandom, $urandom, $urandom, $urandom, $urandom_range(1, 32'h7fffffff),
			32'h80000000, 32'h7fffffff);
		push_random(150);
		drain();
		send_idle = 51;
		recv_idle = 24;
		set_all(32'h00030000, 32'h00020000, 32'h00008000, 32'h0, 32'h00000001,
			32'hfffd0000, 32'h00030000);
		push_random(150);
		drain();
		set_all(32'h00008000, 32'h00100000, 32'h00040000, 32'h00010000, 32'h00010000,
			32'h00050000, 32'hfffb0000);
		push_random(150);
		drain();
		send_idle = 0;
		recv_idle = 0;
		set_all($urandom_range(0, 32'h00040000), $urandom_range(0, 32'h00040000),
			$urandom_range(0, 32'h00040000), $urandom_range(0, 32'h00020000),
			$urandom_range(1, 32'h00020000), 32'hff000000, 32'h01000000);
		push_random(150);
		drain();
		set_all(32'h7fffffff, 32'h0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h80000000);
		push_random(150);
		drain();

		$display("Covered %0d input beats and %0d output beats (%0d saturated)",
			beats_in, beats_out, sat_seen);
		$display("across reset, corner and crossed limit settings with varied idling.");
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
